/* sv/pot_average_scale_change_detect_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the potentiometer averaging block
// Concurrent checks sampled on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef POT_AVERAGE_SCALE_CHANGE_DETECT_DEFINES_SVH
`define POT_AVERAGE_SCALE_CHANGE_DETECT_DEFINES_SVH

// Same-cycle implication: prop is written with |-> by the caller
`define PACD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Next-cycle implication: ante holds, then cons in the cycle after
`define PACD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/pacd_pkg.sv */
// ----------------------------------------------------------------------------
// pacd_pkg
// Shared widths, register map, reset values and divider interface types.
// ----------------------------------------------------------------------------
package pacd_pkg;

    // Field widths fixed by the stream and register formats
    localparam int unsigned CHAN_W    = 3;
    localparam int unsigned SAMPLE_W  = 12;
    localparam int unsigned LEVEL_W   = 7;
    localparam int unsigned TDATA_W   = 16;

    // Register map, indexed by paddr[3:2]
    localparam int unsigned PADDR_W   = 4;
    localparam int unsigned PDATA_W   = 32;
    localparam logic [1:0]  REG_IN_LOW  = 2'd0;
    localparam logic [1:0]  REG_IN_HIGH = 2'd1;
    localparam logic [1:0]  REG_OUT_TOP = 2'd2;

    localparam logic [SAMPLE_W-1:0] IN_LOW_RST  = 12'd20;
    localparam logic [SAMPLE_W-1:0] IN_HIGH_RST = 12'd4080;
    localparam logic [LEVEL_W-1:0]  OUT_TOP_RST = 7'd127;

    // Divider: numerator holds |avg - in_low| * out_top, denominator |span|
    localparam int unsigned DIV_NUM_W = SAMPLE_W + LEVEL_W;
    localparam int unsigned DIV_DEN_W = SAMPLE_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } div_rsp_t;

endpackage

/* sv/pacd_div.sv */
// ----------------------------------------------------------------------------
// pacd_div
// Restoring unsigned divider, one quotient bit per cycle, used for the
// scaled quotient of the linear mapping.
// ----------------------------------------------------------------------------
`include "pot_average_scale_change_detect_defines.svh"

module pacd_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  pacd_pkg::div_req_t req,
    output pacd_pkg::div_rsp_t rsp
);

    localparam int unsigned NUM_W = pacd_pkg::DIV_NUM_W;
    localparam int unsigned DEN_W = pacd_pkg::DIV_DEN_W;
    localparam int unsigned CNT_W = pacd_pkg::DIV_CNT_W;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   trial_sub;
    logic             trial_ge;
    logic             last_step;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        trial_sub = trial - {1'b0, den_reg};
        trial_ge  = trial >= {1'b0, den_reg};
        last_step = busy_reg && (cnt_reg == CNT_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= last_step;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Shift the numerator out as the quotient shifts in
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.num;
            rem_reg <= '0;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            rem_reg <= trial_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], trial_ge};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

    `PACD_ASSERT(a_div_no_restart, req.start |-> !busy_reg, "divider restarted while busy")
    `PACD_ASSERT(a_div_den_nonzero, req.start |-> (req.den != '0), "divider started with zero")
    `PACD_ASSERT_NEXT(a_div_done_pulse, done_reg, !done_reg && !busy_reg, "done not a pulse")

endmodule

/* sv/pot_average_scale_change_detect.sv */
// ----------------------------------------------------------------------------
// pot_average_scale_change_detect
// Per-channel moving average of ADC samples, linear rescale with saturation,
// and change detection on the scaled level.
// ----------------------------------------------------------------------------
// One sample is taken at a time; s_axis_tready is low until it is finished.
// Each sample passes in order through the accepting cycle, S_READ and S_UPD
// (read the oldest sample from the history memory, fold the new one into
// the running total), S_AVG (total / WINDOW by reciprocal multiplication),
// S_MUL (form the scaled product), S_PROD (start the shared bit-serial
// divider), S_QUO (its 19 steps and done cycle) and S_SEND (hand the level
// on). S_QUO is skipped when in_high equals in_low; a sample whose channel
// number is beyond the configured count is accepted and dropped. A changed
// level is placed in an output register, so the next sample may be accepted
// while that result waits for m_axis_tready; a further changed level holds
// in S_SEND until that register frees. The sample history is cleared at
// reset through per-entry valid bits; no clearing pass is needed. Registers
// lie at byte addresses 0 (in_low), 4 (in_high) and 8 (out_top); the user
// must write them only while the block is idle; the block leaves it unchecked.
// ----------------------------------------------------------------------------
`include "pot_average_scale_change_detect_defines.svh"

module pot_average_scale_change_detect
#(
    parameter int unsigned CHANNELS    = 5,
    parameter int unsigned WINDOW      = 10,
    parameter int unsigned SAMPLE_BITS = 12
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    // APB configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pacd_pkg::PADDR_W-1:0]       paddr,
    input  logic [pacd_pkg::PDATA_W-1:0]       pwdata,
    output logic [pacd_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready,
    // Sample stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [pacd_pkg::TDATA_W-1:0]       s_axis_tdata,  // channel[2:0], sample[14:3]
    // Level stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [pacd_pkg::TDATA_W-1:0]       m_axis_tdata   // out_channel[2:0], level[9:3]
);

    localparam int unsigned SW     = pacd_pkg::SAMPLE_W;
    localparam int unsigned LW     = pacd_pkg::LEVEL_W;
    localparam int unsigned CW     = pacd_pkg::CHAN_W;
    localparam int unsigned NUM_W  = pacd_pkg::DIV_NUM_W;
    localparam int unsigned DEN_W  = pacd_pkg::DIV_DEN_W;
    localparam int unsigned SBU    = (SAMPLE_BITS < SW) ? SAMPLE_BITS : SW;
    localparam int unsigned TOT_W  = $clog2(WINDOW * ((1 << SBU) - 1) + 1);
    localparam int unsigned DEPTH  = CHANNELS * WINDOW;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned SLOT_W = $clog2(WINDOW);
    // Reciprocal of WINDOW, exact for every total of TOT_W bits
    localparam int unsigned RCP_SH = TOT_W + $clog2(WINDOW);
    localparam int unsigned RCP_M  = ((1 << RCP_SH) + WINDOW - 1) / WINDOW;
    localparam int unsigned RCP_W  = $clog2(RCP_M + 1);
    localparam int unsigned PRD_W  = TOT_W + RCP_W;

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_READ = 8'b00000010,
        S_UPD  = 8'b00000100,
        S_AVG  = 8'b00001000,
        S_MUL  = 8'b00010000,
        S_PROD = 8'b00100000,
        S_QUO  = 8'b01000000,
        S_SEND = 8'b10000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Configuration
    logic [SW-1:0] in_low_reg;
    logic [SW-1:0] in_high_reg;
    logic [LW-1:0] out_top_reg;
    logic          cfg_wr;

    // Per-channel state
    logic [SLOT_W-1:0] slot_reg  [CHANNELS];
    logic [TOT_W-1:0]  total_reg [CHANNELS];
    logic [LW-1:0]     last_reg  [CHANNELS];

    // History memory with per-entry valid bits cleared at reset
    logic [SBU-1:0]    hist_mem [DEPTH];
    logic [DEPTH-1:0]  hist_vld_reg;
    logic [SBU-1:0]    rd_data_reg;
    logic              rd_vld_reg;
    logic [ADDR_W-1:0] addr;

    // Item in flight
    logic [CH_W-1:0]   ch_reg;
    logic [SBU-1:0]    smp_reg;
    logic [SW-1:0]     avg_reg;
    logic [NUM_W-1:0]  prod_reg;
    logic              neg_reg;
    logic              ge_reg;
    logic [LW-1:0]     lvl_reg;

    // Output register
    logic              out_vld_reg;
    logic [CW-1:0]     out_ch_reg;
    logic [LW-1:0]     out_lvl_reg;

    logic              in_take;
    logic              ch_ok;
    logic [SLOT_W-1:0] slot_cur;
    logic [SLOT_W-1:0] slot_adv;
    logic [TOT_W-1:0]  total_cur;
    logic [TOT_W-1:0]  total_new;
    logic [LW-1:0]     last_cur;
    logic [PRD_W-1:0]  avg_prod;
    logic [SW-1:0]     avg_next;
    logic [SW:0]       diff;
    logic [SW-1:0]     diff_abs;
    logic [SW:0]       span;
    logic [SW-1:0]     span_abs;
    logic              span_zero;
    logic [LW-1:0]     lvl_quo;
    logic              lvl_changed;
    logic              out_free;
    logic              out_load;

    pacd_pkg::div_req_t div_req;
    pacd_pkg::div_rsp_t div_rsp;

    // ------------------------------------------------------------------
    // APB registers
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_low_reg  <= pacd_pkg::IN_LOW_RST;
            in_high_reg <= pacd_pkg::IN_HIGH_RST;
            out_top_reg <= pacd_pkg::OUT_TOP_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                pacd_pkg::REG_IN_LOW:  in_low_reg  <= pwdata[SW-1:0];
                pacd_pkg::REG_IN_HIGH: in_high_reg <= pwdata[SW-1:0];
                pacd_pkg::REG_OUT_TOP: out_top_reg <= pwdata[LW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            pacd_pkg::REG_IN_LOW:  prdata = pacd_pkg::PDATA_W'(in_low_reg);
            pacd_pkg::REG_IN_HIGH: prdata = pacd_pkg::PDATA_W'(in_high_reg);
            pacd_pkg::REG_OUT_TOP: prdata = pacd_pkg::PDATA_W'(out_top_reg);
            default:               prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign ch_ok         = (32'(s_axis_tdata[CW-1:0]) < CHANNELS);

    always_comb
    begin
        slot_cur  = slot_reg[ch_reg];
        total_cur = total_reg[ch_reg];
        last_cur  = last_reg[ch_reg];
        slot_adv  = (slot_cur == SLOT_W'(WINDOW - 1)) ? '0 : slot_cur + SLOT_W'(1);
        addr      = ADDR_W'(ch_reg * WINDOW) + ADDR_W'(slot_cur);
        total_new = total_cur - (rd_vld_reg ? TOT_W'(rd_data_reg) : '0) + TOT_W'(smp_reg);

        // Truncated window average by reciprocal multiplication
        avg_prod  = PRD_W'(total_cur) * PRD_W'(RCP_M);
        avg_next  = SW'(avg_prod >> RCP_SH);

        diff      = {1'b0, avg_reg} - {1'b0, in_low_reg};
        diff_abs  = diff[SW] ? SW'(-diff) : diff[SW-1:0];
        span      = {1'b0, in_high_reg} - {1'b0, in_low_reg};
        span_abs  = span[SW] ? SW'(-span) : span[SW-1:0];
        span_zero = (span == '0);

        // Truncated quotient, then saturate to 0..out_top
        if (neg_reg)
        begin
            lvl_quo = '0;
        end
        else if (div_rsp.quo > NUM_W'(out_top_reg))
        begin
            lvl_quo = out_top_reg;
        end
        else
        begin
            lvl_quo = div_rsp.quo[LW-1:0];
        end

        lvl_changed = (lvl_reg != last_cur);
        out_free    = !out_vld_reg || m_axis_tready;
        out_load    = (state_reg == S_SEND) && lvl_changed && out_free;
    end

    // Shared divider for the scaled quotient
    always_comb
    begin
        div_req.start = (state_reg == S_PROD) && !span_zero;
        div_req.num   = prod_reg;
        div_req.den   = DEN_W'(span_abs);
    end

    pacd_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take && ch_ok)
                begin
                    state_next = S_READ;
                end
            end
            S_READ: state_next = S_UPD;
            S_UPD:  state_next = S_AVG;
            S_AVG:  state_next = S_MUL;
            S_MUL:  state_next = S_PROD;
            S_PROD: state_next = span_zero ? S_SEND : S_QUO;
            S_QUO:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_SEND;
                end
            end
            S_SEND:
            begin
                if (!lvl_changed || out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            out_vld_reg  <= 1'b0;
            hist_vld_reg <= '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                slot_reg[c]  <= '0;
                total_reg[c] <= '0;
                last_reg[c]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_UPD)
            begin
                hist_vld_reg[addr] <= 1'b1;
                slot_reg[ch_reg]   <= slot_adv;
                total_reg[ch_reg]  <= total_new;
            end
            if (out_load)
            begin
                out_vld_reg      <= 1'b1;
                last_reg[ch_reg] <= lvl_reg;
            end
            else if (m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // History memory: read the oldest sample, then overwrite it
    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            rd_data_reg <= hist_mem[addr];
            rd_vld_reg  <= hist_vld_reg[addr];
        end
        if (state_reg == S_UPD)
        begin
            hist_mem[addr] <= smp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ch_reg  <= CH_W'(s_axis_tdata[CW-1:0]);
            smp_reg <= s_axis_tdata[CW +: SBU];
        end
        if (state_reg == S_AVG)
        begin
            avg_reg <= avg_next;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= NUM_W'(diff_abs) * NUM_W'(out_top_reg);
            neg_reg  <= diff[SW] ^ span[SW];
            ge_reg   <= !diff[SW];
        end
        if ((state_reg == S_PROD) && span_zero)
        begin
            lvl_reg <= ge_reg ? out_top_reg : '0;
        end
        else if ((state_reg == S_QUO) && div_rsp.done)
        begin
            lvl_reg <= lvl_quo;
        end
        if (out_load)
        begin
            out_ch_reg  <= CW'(ch_reg);
            out_lvl_reg <= lvl_reg;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {(pacd_pkg::TDATA_W - CW - LW)'(0), out_lvl_reg, out_ch_reg};

    `PACD_ASSERT(a_level_in_range, m_axis_tvalid |-> (out_lvl_reg <= out_top_reg), "level above out_top")
    `PACD_ASSERT(a_slot_in_window, (state_reg != S_IDLE) |-> ({1'b0, slot_cur} < (SLOT_W + 1)'(WINDOW)), "write slot past window")
    `PACD_ASSERT_NEXT(a_load_holds_level, out_load, m_axis_tvalid && (out_lvl_reg == $past(lvl_reg)), "result not loaded")

endmodule

/* tb/tb_pot_average_scale_change_detect.sv */
// ----------------------------------------------------------------------------
// Testbench for pot_average_scale_change_detect
// Drives random and directed ADC samples over the sample stream, programs the
// span and top registers over APB between phases, and checks every level
// transaction against a per-channel moving-average and rescale predictor.
// ----------------------------------------------------------------------------
module tb_pot_average_scale_change_detect;

    import pacd_pkg::*;

    localparam int unsigned CHANNELS    = 5;
    localparam int unsigned WINDOW      = 10;
    localparam int unsigned SAMPLE_MAX  = 4095;
    localparam int unsigned SETTLE      = 100;   // covers one sample in flight
    localparam int unsigned IDLE_LIMIT  = 3000;
    localparam int unsigned PHASES      = 8;
    localparam int unsigned PHASE_ITEMS = 150;

    typedef struct packed {
        logic [CHAN_W-1:0]  ch;
        logic [LEVEL_W-1:0] level;
    } level_result_t;

    class pot_level_scoreboard;
        logic [SAMPLE_W-1:0] in_low;
        logic [SAMPLE_W-1:0] in_high;
        logic [LEVEL_W-1:0]  out_top;
        logic [SAMPLE_W-1:0] history [CHANNELS][WINDOW];
        int unsigned         slot [CHANNELS];
        int unsigned         total [CHANNELS];
        logic [LEVEL_W-1:0]  last_level [CHANNELS];
        level_result_t       pending_levels [$];
        int unsigned         errors;

        function void clear();
            in_low  = IN_LOW_RST;
            in_high = IN_HIGH_RST;
            out_top = OUT_TOP_RST;
            errors  = 0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                slot[c]       = 0;
                total[c]      = 0;
                last_level[c] = '0;
                for (int k = 0; k < WINDOW; k++)
                    history[c][k] = '0;
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [PDATA_W-1:0] val);
            case (idx)
                REG_IN_LOW:  in_low  = val[SAMPLE_W-1:0];
                REG_IN_HIGH: in_high = val[SAMPLE_W-1:0];
                REG_OUT_TOP: out_top = val[LEVEL_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [LEVEL_W-1:0] scaled_level(int unsigned avg);
            longint span;
            longint top;
            longint v;
            span = longint'(in_high) - longint'(in_low);
            top  = longint'(out_top);
            if (span == 0)
                return (avg >= in_low) ? out_top : '0;
            // signed division truncates toward zero, then clamp to 0..out_top
            v = ((longint'(avg) - longint'(in_low)) * top) / span;
            if (v < 0)
                v = 0;
            if (v > top)
                v = top;
            return v[LEVEL_W-1:0];
        endfunction

        function void take_sample(logic [CHAN_W-1:0] ch, logic [SAMPLE_W-1:0] smp);
            int unsigned        c;
            int unsigned        avg;
            logic [LEVEL_W-1:0] lvl;
            level_result_t      res;
            if (ch >= CHANNELS)
                return;
            c = ch;
            total[c] = total[c] - history[c][slot[c]] + smp;
            history[c][slot[c]] = smp;
            slot[c] = (slot[c] == WINDOW - 1) ? 0 : slot[c] + 1;
            avg = total[c] / WINDOW;
            lvl = scaled_level(avg);
            if (lvl != last_level[c])
            begin
                last_level[c] = lvl;
                res.ch        = ch;
                res.level     = lvl;
                pending_levels.push_back(res);
            end
        endfunction

        function void check_level(logic [CHAN_W-1:0] ch, logic [LEVEL_W-1:0] lvl);
            level_result_t exp_res;
            if (pending_levels.size() == 0)
            begin
                $error("unexpected level transaction: out_channel %0d level %0d", ch, lvl);
                errors++;
                return;
            end
            exp_res = pending_levels.pop_front();
            if (ch !== exp_res.ch)
            begin
                $error("out_channel: expected %0d, got %0d", exp_res.ch, ch);
                errors++;
            end
            if (lvl !== exp_res.level)
            begin
                $error("level: expected %0d, got %0d", exp_res.level, lvl);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [TDATA_W-1:0]  s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [TDATA_W-1:0]  m_axis_tdata;

    pot_level_scoreboard sb;
    bit                  steady;
    int                  drift [CHANNELS];
    int unsigned         stall_left;
    int unsigned         quiet_cycles;

    pot_average_scale_change_detect dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CHAN_W-1:0] pick_channel();
        if ($urandom_range(0, 99) < 6)
            return $urandom_range(CHANNELS, 7);
        return $urandom_range(0, CHANNELS - 1);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample(logic [CHAN_W-1:0] ch);
        int unsigned r;
        int          v;
        r = $urandom_range(0, 99);
        if (ch >= CHANNELS || r < 35)
            v = $urandom_range(0, SAMPLE_MAX);
        else if (r < 75)
        begin
            // slow wander around a per-channel set point
            drift[ch] = drift[ch] + $urandom_range(0, 400) - 200;
            if (drift[ch] < 0)
                drift[ch] = 0;
            if (drift[ch] > SAMPLE_MAX)
                drift[ch] = SAMPLE_MAX;
            v = drift[ch] + $urandom_range(0, 64) - 32;
        end
        else if (r < 85)
            v = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
        else if (r < 93)
            v = sb.in_low + $urandom_range(0, 60) - 30;
        else
            v = sb.in_high + $urandom_range(0, 60) - 30;
        if (v < 0)
            v = 0;
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic apb_write(logic [1:0] idx, logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.write_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_regs(int unsigned lo, int unsigned hi, int unsigned top);
        apb_write(REG_IN_LOW, lo);
        apb_write(REG_IN_HIGH, hi);
        apb_write(REG_OUT_TOP, top);
    endtask

    task automatic send_sample(logic [CHAN_W-1:0] ch, logic [SAMPLE_W-1:0] smp);
        int unsigned gap;
        gap = idle_gap();
        // hold valid high across back-to-back transactions
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, smp, ch};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.take_sample(ch, smp);
    endtask

    // wait for every expected level, then let a sample with no result finish
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_levels.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // level stream receiver with random back-pressure
    initial
    begin
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_level(m_axis_tdata[2:0], m_axis_tdata[9:3]);
            if (!rst_n)
                m_axis_tready <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 99) < 30)
                    stall_left = idle_gap();
            end
        end
    end

    // watchdog: end the run if nothing moves for too long
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned lo;
        int unsigned hi;
        int unsigned top;
        int unsigned n;
        logic [CHAN_W-1:0] ch;

        sb = new();
        sb.clear();
        steady = 1'b0;
        for (int c = 0; c < CHANNELS; c++)
            drift[c] = SAMPLE_MAX / 2;

        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // equal span: step from 0 straight to out_top once the average reaches in_low
        program_regs(2000, 2000, 127);
        repeat (5) send_sample(0, SAMPLE_MAX);
        send_sample(7, SAMPLE_MAX);
        send_sample(5, 0);
        send_sample(1, 0);
        send_sample(4, 12'haaa);
        send_sample(3, 12'h555);
        drain();

        // reversed span
        program_regs(SAMPLE_MAX, 0, 127);
        send_sample(0, 0);
        send_sample(0, 0);
        send_sample(2, SAMPLE_MAX);
        send_sample(2, SAMPLE_MAX);
        drain();

        // zero top forces every level to 0
        program_regs(20, 4080, 0);
        send_sample(0, SAMPLE_MAX);
        send_sample(2, 0);
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: begin lo = IN_LOW_RST; hi = IN_HIGH_RST; top = OUT_TOP_RST; end
                1: begin lo = 0; hi = SAMPLE_MAX; top = 127; end
                2: begin lo = 0; hi = 1; top = 1; end
                4: begin lo = SAMPLE_MAX; hi = 0; top = 127; end
                5: begin
                    lo  = $urandom_range(0, SAMPLE_MAX);
                    hi  = lo;
                    top = $urandom_range(1, 127);
                end
                6: begin
                    lo  = $urandom_range(0, SAMPLE_MAX - 1);
                    hi  = $urandom_range(lo + 1, SAMPLE_MAX);
                    top = 1;
                end
                default: begin
                    lo  = $urandom_range(0, SAMPLE_MAX - 1);
                    hi  = $urandom_range(lo + 1, SAMPLE_MAX);
                    top = $urandom_range(1, 127);
                end
            endcase
            program_regs(lo, hi, top);
            steady = (ph == 3);
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                ch = pick_channel();
                send_sample(ch, pick_sample(ch));
                if (ch < CHANNELS)
                    n++;
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending_levels.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/pacd_pkg.sv
sv/pacd_div.sv
sv/pot_average_scale_change_detect.sv
tb/tb_pot_average_scale_change_detect.sv
